// ----- design/tlpt_pkg.sv -----
// shared types, constants and address helpers for the two-level page table manager
package tlpt_pkg;

    // geometry of the two-level table
    localparam int DIR_BITS    = 4;
    localparam int TABLE_BITS  = 8;
    localparam int PTE_BITS    = DIR_BITS + TABLE_BITS;
    localparam int PAGE_SHIFT  = 12;
    localparam int DIR_DEPTH   = 1 << DIR_BITS;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int PTE_DEPTH   = 1 << PTE_BITS;

    // entry layout
    localparam logic [31:0] FRAME_MASK    = 32'hFFFF_F000;
    localparam logic [31:0] FLAG_PRESENT  = 32'h0000_0001;
    localparam logic [31:0] FLAG_WRITABLE = 32'h0000_0002;

    // operation codes
    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_UNMAP = 2'd1;
    localparam logic [1:0] CMD_XLATE = 2'd2;

    // decoupling queue between front and back (depth is a power of two)
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // input word
    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] virt_addr;
        logic [31:0] phys_addr;
        logic [11:0] attr_flags;
        logic [31:0] new_table_frame;
        logic [31:0] new_page_frame;
    } in_item_t;

    // result word
    typedef struct packed {
        logic        ok;
        logic [31:0] frame_out;
        logic        table_frame_used;
        logic        page_frame_used;
    } out_item_t;

    // decoded operation handed from front to back
    typedef struct packed {
        logic [1:0]            cmd;
        logic [DIR_BITS-1:0]   dir_idx;
        logic [TABLE_BITS-1:0] tbl_idx;
        logic [31:0]           map_entry;
        logic                  page_used;
        logic [31:0]           table_entry;
    } op_t;

    // directory index of a virtual address
    function automatic logic [DIR_BITS-1:0] dir_of(input logic [23:0] va);
        logic [31:0] ext;
        ext = 32'(va);
        return ext[PAGE_SHIFT+TABLE_BITS +: DIR_BITS];
    endfunction

    // table index of a virtual address
    function automatic logic [TABLE_BITS-1:0] tbl_of(input logic [23:0] va);
        logic [31:0] ext;
        ext = 32'(va);
        return ext[PAGE_SHIFT +: TABLE_BITS];
    endfunction

endpackage

// ----- design/tlpt_front.sv -----
// front end: accepts request words and decodes them into operations
module tlpt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tlpt_pkg::in_item_t s_data,
    output logic              op_valid,
    input  logic              op_ready,
    output tlpt_pkg::op_t     op_data
);
    import tlpt_pkg::*;

    logic fr_valid_reg, fr_valid_next;
    op_t  fr_op_reg;
    op_t  dec_op;
    logic accept;
    logic [31:0] page_frame;

    // decode fields and build the candidate entries
    always_comb begin
        page_frame         = (s_data.phys_addr == 32'd0) ? s_data.new_page_frame
                                                         : s_data.phys_addr;
        dec_op.cmd         = s_data.cmd;
        dec_op.dir_idx     = dir_of(s_data.virt_addr);
        dec_op.tbl_idx     = tbl_of(s_data.virt_addr);
        dec_op.map_entry   = (page_frame & FRAME_MASK) | FLAG_PRESENT
                             | 32'(s_data.attr_flags);
        dec_op.page_used   = (s_data.phys_addr == 32'd0);
        dec_op.table_entry = (s_data.new_table_frame & FRAME_MASK)
                             | FLAG_PRESENT | FLAG_WRITABLE;
    end

    // one-deep holding stage
    assign s_ready  = !fr_valid_reg || op_ready;
    assign accept   = s_valid && s_ready;
    assign op_valid = fr_valid_reg;
    assign op_data  = fr_op_reg;

    always_comb begin
        if (accept) begin
            fr_valid_next = 1'b1;
        end else if (op_ready) begin
            fr_valid_next = 1'b0;
        end else begin
            fr_valid_next = fr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    // operation payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            fr_op_reg <= dec_op;
        end
    end

endmodule

// ----- design/tlpt_queue.sv -----
// small fifo of decoded operations between front and back
module tlpt_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  tlpt_pkg::op_t in_data,
    output logic          out_valid,
    input  logic          out_pop,
    output tlpt_pkg::op_t out_data
);
    import tlpt_pkg::*;

    op_t                       slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      push;

    assign in_ready  = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = out_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !out_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && out_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        out_pop |-> count_reg != '0)
        else $error("queue popped while empty");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !out_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH)) |-> !push)
        else $error("queue written while full");
`endif

endmodule

// ----- design/tlpt_back.sv -----
// back end: directory, page entry memory, table clearing and result register
module tlpt_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  tlpt_pkg::op_t      q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tlpt_pkg::out_item_t m_data
);
    import tlpt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLEAR = 3'b010,
        ST_EXEC  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    // directory entries in flops, page entries in memory
    logic [31:0]           dir_reg [DIR_DEPTH];
    logic [31:0]           pte_mem [PTE_DEPTH];
    logic [31:0]           rd_data_reg;

    logic [TABLE_BITS-1:0] clear_cnt_reg, clear_cnt_next;
    op_t                   op_reg;
    logic                  tused_reg, tused_next;
    logic                  dir_ok_reg, dir_ok_next;
    logic                  zero_reg, zero_next;

    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, res;

    logic                  dir_we;
    logic [31:0]           head_dir;
    logic                  mem_we;
    logic [PTE_BITS-1:0]   mem_waddr;
    logic [31:0]           mem_wdata;
    logic                  out_load;
    logic [31:0]           entry;
    logic                  clear_last;

    assign head_dir   = dir_reg[q_data.dir_idx];
    assign entry      = zero_reg ? 32'd0 : rd_data_reg;
    assign clear_last = (clear_cnt_reg == '1);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        dir_we         = 1'b0;
        tused_next     = tused_reg;
        dir_ok_next    = dir_ok_reg;
        zero_next      = zero_reg;
        clear_cnt_next = clear_cnt_reg;
        mem_we         = 1'b0;
        mem_waddr      = {op_reg.dir_idx, op_reg.tbl_idx};
        mem_wdata      = 32'd0;
        out_load       = 1'b0;
        res            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_data.cmd == CMD_MAP && !head_dir[0]) begin
                        // new page table: install directory entry, then clear
                        dir_we         = 1'b1;
                        tused_next     = 1'b1;
                        dir_ok_next    = 1'b1;
                        zero_next      = 1'b1;
                        clear_cnt_next = '0;
                        state_next     = ST_CLEAR;
                    end else begin
                        tused_next  = 1'b0;
                        dir_ok_next = head_dir[0];
                        zero_next   = 1'b0;
                        state_next  = ST_EXEC;
                    end
                end
            end
            ST_CLEAR: begin
                mem_we         = 1'b1;
                mem_waddr      = {op_reg.dir_idx, clear_cnt_reg};
                mem_wdata      = 32'd0;
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (clear_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (op_reg.cmd)
                        CMD_MAP: begin
                            res.table_frame_used = tused_reg;
                            if (!entry[0]) begin
                                mem_we              = 1'b1;
                                mem_wdata           = op_reg.map_entry;
                                res.ok              = 1'b1;
                                res.page_frame_used = op_reg.page_used;
                            end
                        end
                        CMD_UNMAP: begin
                            if (dir_ok_reg && entry[0]) begin
                                mem_we        = 1'b1;
                                mem_wdata     = entry & ~FLAG_PRESENT;
                                res.ok        = 1'b1;
                                res.frame_out = entry & FRAME_MASK;
                            end
                        end
                        CMD_XLATE: begin
                            if (dir_ok_reg && entry[0]) begin
                                res.ok        = 1'b1;
                                res.frame_out = entry & FRAME_MASK;
                            end
                        end
                        default: begin
                            res = '0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output handshake
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            clear_cnt_reg <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    // directory store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIR_DEPTH; i++) begin
                dir_reg[i] <= 32'd0;
            end
        end else if (dir_we) begin
            dir_reg[q_data.dir_idx] <= q_data.table_entry;
        end
    end

    // operation context and result payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            op_reg <= q_data;
        end
        tused_reg  <= tused_next;
        dir_ok_reg <= dir_ok_next;
        zero_reg   <= zero_next;
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    // page entry memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            pte_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= pte_mem[{q_data.dir_idx, q_data.tbl_idx}];
        end
    end

`ifndef SYNTH
    a_clear_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clear_last) |=> (state_reg == ST_EXEC && clear_cnt_reg == '0))
        else $error("table clear did not finish cleanly");
    a_clear_only_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (op_reg.cmd == CMD_MAP && tused_reg && zero_reg))
        else $error("table clear outside a new-table map");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !(m_valid_reg && !m_ready))
        else $error("result overwritten before it was taken");
    a_exec_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (state_reg == ST_IDLE && m_valid_reg))
        else $error("result load did not return to idle");
`endif

endmodule

// ----- design/two_level_page_table_manager_top.sv -----
// top level of the two-level page table manager
//
// Usage: one request word in on s_ (cmd, virt_addr, phys_addr, attr_flags,
// new_table_frame, new_page_frame), one result word out on m_ (ok, frame_out,
// table_frame_used, page_frame_used), both valid/ready. Every request gives
// exactly one result, in order.
// Path: front holding register, queue, back end pop with the page entry read, then
// the result register; a map that creates a new page table first clears its
// TABLE_DEPTH (256) page entries, one cleared page entry per cycle through the
// single write port of the page entry memory.
// Back end: it pops an operation with the page entry read, then updates and
// loads the result, and takes the next operation only back in idle; the front stage and the
// 2-deep queue keep taking words while the back end works or is clearing.
// Reset: directory entries read as not present; no clearing pass is needed,
// since a page table is only read after its directory entry is made, which
// clears it first.
// Stall: a result waits in the output register while m_ready is low; the
// back end holds its next result, the queue and front fill, then s_ready drops.
module two_level_page_table_manager_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tlpt_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tlpt_pkg::out_item_t m_data
);
    import tlpt_pkg::*;

    logic fq_valid, fq_ready;
    op_t  fq_data;
    logic qb_valid, qb_pop;
    op_t  qb_data;

    // accept and decode
    tlpt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .op_valid (fq_valid),
        .op_ready (fq_ready),
        .op_data  (fq_data)
    );

    // decoupling queue
    tlpt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_pop   (qb_pop),
        .out_data  (qb_data)
    );

    // table walk and update
    tlpt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (qb_valid),
        .q_pop   (qb_pop),
        .q_data  (qb_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- tb/tlpt_walk_monitor.sv -----
// channel monitor, page walk predictor and result comparison for the page table manager
module tlpt_walk_monitor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  tlpt_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  tlpt_pkg::out_item_t m_data,
    output int                  errors,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import tlpt_pkg::*;

    // private copy of the directory and the page entries
    logic [31:0] dir_mem [DIR_DEPTH];
    logic [31:0] pte_mem [PTE_DEPTH];
    out_item_t   walk_results [$];
    int          fails;

    function automatic logic present(input logic [31:0] entry);
        return (entry & FLAG_PRESENT) != 32'd0;
    endfunction

    // perform one request on the private tables and return its result word
    function automatic out_item_t page_walk(input in_item_t w);
        logic [DIR_BITS-1:0]   d;
        logic [TABLE_BITS-1:0] t;
        logic [PTE_BITS-1:0]   p;
        logic [31:0]           frame;
        out_item_t             r;
        d = w.virt_addr[PAGE_SHIFT+TABLE_BITS +: DIR_BITS];
        t = w.virt_addr[PAGE_SHIFT +: TABLE_BITS];
        p = {d, t};
        r = '0;
        case (w.cmd)
            CMD_MAP: begin
                // a missing directory entry takes the table frame and wipes its table
                if (!present(dir_mem[d])) begin
                    dir_mem[d] = (w.new_table_frame & FRAME_MASK) | FLAG_PRESENT
                                 | FLAG_WRITABLE;
                    r.table_frame_used = 1'b1;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        pte_mem[{d, TABLE_BITS'(i)}] = 32'd0;
                    end
                end
                if (!present(pte_mem[p])) begin
                    frame = w.phys_addr;
                    if (frame == 32'd0) begin
                        frame             = w.new_page_frame;
                        r.page_frame_used = 1'b1;
                    end
                    pte_mem[p] = (frame & FRAME_MASK) | FLAG_PRESENT | {20'd0, w.attr_flags};
                    r.ok       = 1'b1;
                end
            end
            CMD_UNMAP: begin
                // drop present, keep frame and other bits
                if (present(dir_mem[d]) && present(pte_mem[p])) begin
                    pte_mem[p]  = pte_mem[p] & ~FLAG_PRESENT;
                    r.frame_out = pte_mem[p] & FRAME_MASK;
                    r.ok        = 1'b1;
                end
            end
            CMD_XLATE: begin
                if (present(dir_mem[d]) && present(pte_mem[p])) begin
                    r.frame_out = pte_mem[p] & FRAME_MASK;
                    r.ok        = 1'b1;
                end
            end
            default: begin
                // unused selector leaves everything alone
            end
        endcase
        return r;
    endfunction

    // watch both channels on each edge
    always @(posedge aclk) begin
        out_item_t due;
        if (!aresetn) begin
            for (int i = 0; i < DIR_DEPTH; i++) dir_mem[i] = 32'd0;
            for (int i = 0; i < PTE_DEPTH; i++) pte_mem[i] = 32'd0;
            walk_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                walk_results.push_back(page_walk(s_data));
            end
            if (m_valid && m_ready) begin
                if (walk_results.size() == 0) begin
                    fails++;
                    $display("%0t: result word with none due: ok %0b frame %h tused %0b pused %0b",
                             $time, m_data.ok, m_data.frame_out, m_data.table_frame_used,
                             m_data.page_frame_used);
                end else begin
                    due = walk_results.pop_front();
                    if (m_data.ok !== due.ok) begin
                        fails++;
                        $display("%0t: ok expected %0b got %0b", $time, due.ok, m_data.ok);
                    end
                    if (m_data.frame_out !== due.frame_out) begin
                        fails++;
                        $display("%0t: frame_out expected %h got %h",
                                 $time, due.frame_out, m_data.frame_out);
                    end
                    if (m_data.table_frame_used !== due.table_frame_used) begin
                        fails++;
                        $display("%0t: table_frame_used expected %0b got %0b",
                                 $time, due.table_frame_used, m_data.table_frame_used);
                    end
                    if (m_data.page_frame_used !== due.page_frame_used) begin
                        fails++;
                        $display("%0t: page_frame_used expected %0b got %0b",
                                 $time, due.page_frame_used, m_data.page_frame_used);
                    end
                end
            end
        end
        outstanding <= walk_results.size();
        errors      <= fails;
    end

endmodule

// ----- tb/two_level_page_table_manager_top_tb.sv -----
// stimulus and verdict for the two-level page table manager
module two_level_page_table_manager_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tlpt_pkg::*;

    localparam int RANDOM_WORDS = 600;
    localparam int POOL_SIZE    = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    int        errors;
    int        outstanding;
    int        send_idle_pct = 11;
    int        recv_idle_pct = 53;
    int        cycle_count   = 0;
    logic [23:0] addr_pool [POOL_SIZE];

    two_level_page_table_manager_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    tlpt_walk_monitor walk_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic in_item_t req(input logic [1:0] c, input logic [23:0] va,
                                     input logic [31:0] pa, input logic [11:0] fl,
                                     input logic [31:0] tf, input logic [31:0] pf);
        in_item_t w;
        w.cmd             = c;
        w.virt_addr       = va;
        w.phys_addr       = pa;
        w.attr_flags      = fl;
        w.new_table_frame = tf;
        w.new_page_frame  = pf;
        return w;
    endfunction

    // offer one request word, with random idle cycles ahead of it
    task automatic send_word(input in_item_t w);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // random request, mostly on a small set of pages so that entries get reused
    function automatic in_item_t random_req();
        int          sel;
        logic [1:0]  c;
        logic [23:0] va;
        logic [31:0] pa;
        logic [31:0] tf;
        logic [31:0] pf;
        sel = $urandom_range(99);
        if (sel < 40)      c = CMD_MAP;
        else if (sel < 62) c = CMD_UNMAP;
        else if (sel < 95) c = CMD_XLATE;
        else               c = 2'd3;
        if ($urandom_range(99) < 75)
            va = {addr_pool[$urandom_range(POOL_SIZE-1)][23:12], 12'($urandom)};
        else
            va = 24'($urandom);
        pa = ($urandom_range(99) < 35) ? 32'd0 : $urandom;
        tf = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
        pf = ($urandom_range(9) == 0) ? 32'd0 : $urandom;
        return req(c, va, pa, 12'($urandom), tf, pf);
    endfunction

    initial begin
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = 24'($urandom);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: misses on an empty table, table creation, allocator frames,
        // double map, unmap twice, remap, zero frames, unused selector, extremes
        send_word(req(CMD_XLATE, 24'h000000, '0, '0, '0, '0));
        send_word(req(CMD_UNMAP, 24'h000000, '0, '0, '0, '0));
        send_word(req(CMD_MAP, 24'h000000, 32'd0, 12'h000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(req(CMD_XLATE, 24'h000ABC, '0, '0, '0, '0));
        send_word(req(CMD_MAP, 24'h000000, 32'h1234_5000, 12'h001, 32'h0BAD_0000, '0));
        send_word(req(CMD_XLATE, 24'h001000, '0, '0, '0, '0));
        send_word(req(CMD_UNMAP, 24'h001000, '0, '0, '0, '0));
        send_word(req(CMD_MAP, 24'hFFFFFF, 32'hFFFF_FFFF, 12'hFFF, 32'd0, 32'h5555_5555));
        send_word(req(CMD_XLATE, 24'hFFFFFF, '0, '0, '0, '0));
        send_word(req(CMD_UNMAP, 24'hFFFFFF, '0, '0, '0, '0));
        send_word(req(CMD_UNMAP, 24'hFFFFFF, '0, '0, '0, '0));
        send_word(req(CMD_XLATE, 24'hFFFFFF, '0, '0, '0, '0));
        send_word(req(CMD_MAP, 24'hFFF000, 32'd0, 12'h004, '0, 32'd0));
        send_word(req(CMD_XLATE, 24'hFFF123, '0, '0, '0, '0));
        send_word(req(2'd3, 24'hFFF000, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(req(CMD_MAP, 24'hFFFFFF, 32'h1234_5678, 12'h002, '0, '0));
        send_word(req(CMD_XLATE, 24'hFFFFFF, '0, '0, '0, '0));
        send_word(req(CMD_MAP, 24'h5A5000, 32'h8000_0000, 12'hFFE, 32'h7FFF_FFFF, '0));
        send_word(req(CMD_UNMAP, 24'h5A5000, '0, '0, '0, '0));
        send_word(req(CMD_MAP, 24'h5A5000, 32'd0, 12'h555, '0, 32'hA5A5_A5A5));
        send_word(req(CMD_XLATE, 24'h5A5FFF, '0, '0, '0, '0));

        // random words in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 53;
                recv_idle_pct = 11;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < RANDOM_WORDS / 3; n++) send_word(random_req());
        end
        s_valid <= 1'b0;

        // drain, then allow for trailing words
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
